// ===== hdl/iqh_pkg.sv =====
// Shared constants, register codes and stage types of the invertible quotient hash.
package iqh_pkg;

  localparam int KEY_W     = 64;
  localparam int MOD_W     = KEY_W + 1;
  localparam int SIZE_W    = 33;
  localparam int ADDR_W    = 32;
  localparam int PROD_W    = KEY_W + SIZE_W;
  localparam int RED_CELLS = KEY_W;
  localparam int MUL_CELLS = PROD_W;
  localparam int DIV_CELLS = KEY_W;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;

  localparam logic CMD_HASH    = 1'b0;
  localparam logic CMD_RECOVER = 1'b1;

  typedef enum logic [1:0] {
    REG_TABLE_SIZE = 2'd0,
    REG_PRIME      = 2'd1,
    REG_MULT       = 2'd2,
    REG_INV        = 2'd3
  } reg_idx_t;

  // Payload handed from one modular cell to the next.
  typedef struct packed {
    logic              cmd;
    logic [KEY_W-1:0]  r;
    logic [KEY_W-1:0]  x;
    logic [PROD_W-1:0] bits;
    logic [PROD_W-1:0] aux;
  } mm_t;

  // Payload handed from one divider cell to the next.
  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] rem;
    logic [KEY_W-1:0]  dq;
  } dv_t;

endpackage

// ===== hdl/iqh_if.sv =====
// Stream interfaces of the hash input and result channels.
interface iqh_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] parent_location;
  logic [31:0] item_id;
  logic [31:0] home_address;
  logic [63:0] stored_quotient;
  modport source (output valid, command, parent_location, item_id, home_address,
                  stored_quotient, input ready);
  modport sink (input valid, command, parent_location, item_id, home_address,
                stored_quotient, output ready);
endinterface

interface iqh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address_out;
  logic [63:0] quotient_out;
  logic [63:0] recovered_item;
  logic [31:0] recovered_parent;
  modport source (output valid, address_out, quotient_out, recovered_item,
                  recovered_parent, input ready);
  modport sink (input valid, address_out, quotient_out, recovered_item,
                recovered_parent, output ready);
endinterface

// ===== hdl/iqh_front.sv =====
// Front stages: key product in two 32-bit lanes and operand selection.
module iqh_front import iqh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic               cmd_i,
  input  logic [31:0]        parent_i,
  input  logic [31:0]        item_i,
  input  logic [31:0]        addr_i,
  input  logic [63:0]        quot_i,
  input  logic [SIZE_W-1:0]  size_i,
  input  logic [KEY_W-1:0]   mult_i,
  input  logic [KEY_W-1:0]   inv_i,
  input  logic [MOD_W-1:0]   modulus_i,
  output logic               vld_o,
  output mm_t                d_o
);

  logic              vld0_r, vld1_r;
  logic              cmd0_r, cmd1_r;
  logic [64:0]       lo_r, hi_r;
  logic [31:0]       add_r;
  logic [KEY_W-1:0]  x0_r, x1_r;
  logic [PROD_W-1:0] v1_r;
  logic [PROD_W-1:0] v_nxt;
  logic [31:0]       a_lo, a_hi;

  // Hash mode multiplies the item id, recover mode the stored quotient.
  assign a_lo = (cmd_i == CMD_RECOVER) ? quot_i[31:0] : item_i;
  assign a_hi = (cmd_i == CMD_RECOVER) ? quot_i[63:32] : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
      vld1_r <= vld0_r;
    end
  end

  // First stage: two partial products of the key.
  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= cmd_i;
      lo_r   <= {33'd0, a_lo} * {32'd0, size_i};
      hi_r   <= {33'd0, a_hi} * {32'd0, size_i};
      add_r  <= (cmd_i == CMD_RECOVER) ? addr_i : parent_i;
      x0_r   <= (cmd_i == CMD_RECOVER) ? inv_i : mult_i;
    end
  end

  // Second stage: sum the lanes; the hash key wraps to the key width.
  always_comb begin
    v_nxt = {hi_r, 32'd0} + {32'd0, lo_r} + {65'd0, add_r};
    if (cmd0_r == CMD_HASH) begin
      v_nxt = {{(PROD_W-KEY_W){1'b0}}, v_nxt[KEY_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd0_r;
      v1_r   <= v_nxt;
      x1_r   <= x0_r;
    end
  end

  // The multiplier is first reduced by a run over its own bits with unit step.
  always_comb begin
    d_o.cmd  = cmd1_r;
    d_o.r    = '0;
    d_o.x    = (modulus_i == MOD_W'(1)) ? '0 : KEY_W'(1);
    d_o.bits = {x1_r, {(PROD_W-KEY_W){1'b0}}};
    d_o.aux  = v1_r;
  end
  assign vld_o = vld1_r;

endmodule

// ===== hdl/iqh_mod_cell.sv =====
// One step of a shift-and-add modular product: r = (2r + bit * x) mod modulus.
module iqh_mod_cell import iqh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [MOD_W-1:0] modulus_i,
  input  logic             vld_i,
  input  mm_t              d_i,
  output logic             vld_o,
  output mm_t              d_o
);

  logic              vld_r;
  mm_t               d_r, d_nxt;
  logic [MOD_W:0]    t, p1, p2, sel;

  always_comb begin
    t   = {1'b0, d_i.r, 1'b0} + {2'b00, d_i.x & {KEY_W{d_i.bits[PROD_W-1]}}};
    p1  = {1'b0, modulus_i};
    p2  = {modulus_i, 1'b0};
    // The sum stays below three times the modulus, so two trial subtractions do.
    if (t >= p2) begin
      sel = t - p2;
    end else if (t >= p1) begin
      sel = t - p1;
    end else begin
      sel = t;
    end
    d_nxt      = d_i;
    d_nxt.r    = sel[KEY_W-1:0];
    d_nxt.bits = {d_i.bits[PROD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== hdl/iqh_div_cell.sv =====
// One step of restoring division by the table size: one quotient bit per cell.
module iqh_div_cell import iqh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [SIZE_W-1:0] divisor_i,
  input  logic              vld_i,
  input  dv_t               d_i,
  output logic              vld_o,
  output dv_t               d_o
);

  logic              vld_r;
  dv_t               d_r, d_nxt;
  logic [SIZE_W:0]   t, diff;
  logic              ge;

  // The remainder stays below the divisor, so it fits the table size width.
  always_comb begin
    t      = {d_i.rem, d_i.dq[KEY_W-1]};
    diff   = t - {1'b0, divisor_i};
    ge     = (t >= {1'b0, divisor_i});
    d_nxt.cmd = d_i.cmd;
    d_nxt.rem = ge ? diff[SIZE_W-1:0] : t[SIZE_W-1:0];
    d_nxt.dq  = {d_i.dq[KEY_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== hdl/invertible_quotient_hash_top.sv =====
// Top level of the invertible quotient hash: registers, cell chains and output.
// Invertible quotient hash. One transaction enters per cycle unless the output stalls.
// Two front stages form the key product, a chain of 64 modular cells reduces the
// scramble multiplier, a chain of 97 modular cells builds the modular product one
// key bit per cell, and a chain of 64 divider cells splits the result by the table
// size, one quotient bit per cell. The last divider cell is the output register; a
// stall at the output holds the whole chain. Registers are written over the APB
// port at byte address 8*i and must only change while idle.
module invertible_quotient_hash_top import iqh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  iqh_in_if.sink             in_ch,
  iqh_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  logic [SIZE_W-1:0] size_r;
  logic [KEY_W-1:0]  prime_r, mult_r, inv_r;
  logic [SIZE_W-1:0] size_eff;
  logic [MOD_W-1:0]  modulus;
  reg_idx_t          idx;
  logic              adv;

  logic              red_v [RED_CELLS+1];
  mm_t               red_d [RED_CELLS+1];
  logic              mul_v [MUL_CELLS+1];
  mm_t               mul_d [MUL_CELLS+1];
  logic              div_v [DIV_CELLS+1];
  dv_t               div_d [DIV_CELLS+1];

  // Configuration registers.
  assign idx        = reg_idx_t'(cfg_paddr[PADDR_W-1:3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_W'(1);
      prime_r <= 64'd2305843009213693951;
      mult_r  <= KEY_W'(1);
      inv_r   <= KEY_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        REG_TABLE_SIZE: size_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_PRIME:      prime_r <= cfg_pwdata;
        REG_MULT:       mult_r  <= cfg_pwdata;
        REG_INV:        inv_r   <= cfg_pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TABLE_SIZE: cfg_prdata = {{(PDATA_W-SIZE_W){1'b0}}, size_r};
      REG_PRIME:      cfg_prdata = prime_r;
      REG_MULT:       cfg_prdata = mult_r;
      REG_INV:        cfg_prdata = inv_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // A zero size acts as one; a zero prime acts as 2^64.
  assign size_eff = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign modulus  = {(prime_r == '0), prime_r};

  // The chain moves whenever the output register is free or being drained.
  assign adv         = !div_v[DIV_CELLS] || out_ch.ready;
  assign in_ch.ready = adv;

  iqh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld_i     (in_ch.valid),
    .cmd_i     (in_ch.command),
    .parent_i  (in_ch.parent_location),
    .item_i    (in_ch.item_id),
    .addr_i    (in_ch.home_address),
    .quot_i    (in_ch.stored_quotient),
    .size_i    (size_eff),
    .mult_i    (mult_r),
    .inv_i     (inv_r),
    .modulus_i (modulus),
    .vld_o     (red_v[0]),
    .d_o       (red_d[0])
  );

  // Reduction of the multiplier modulo the prime.
  for (genvar i = 0; i < RED_CELLS; i++) begin : g_red
    iqh_mod_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .modulus_i (modulus),
      .vld_i     (red_v[i]),
      .d_i       (red_d[i]),
      .vld_o     (red_v[i+1]),
      .d_o       (red_d[i+1])
    );
  end

  // Hand over: the reduced multiplier becomes the addend, the key the bit stream.
  always_comb begin
    mul_v[0]      = red_v[RED_CELLS];
    mul_d[0].cmd  = red_d[RED_CELLS].cmd;
    mul_d[0].r    = '0;
    mul_d[0].x    = red_d[RED_CELLS].r;
    mul_d[0].bits = red_d[RED_CELLS].aux;
    mul_d[0].aux  = '0;
  end

  for (genvar i = 0; i < MUL_CELLS; i++) begin : g_mul
    iqh_mod_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .modulus_i (modulus),
      .vld_i     (mul_v[i]),
      .d_i       (mul_d[i]),
      .vld_o     (mul_v[i+1]),
      .d_o       (mul_d[i+1])
    );
  end

  // Split the scrambled or recovered value by the table size.
  always_comb begin
    div_v[0]     = mul_v[MUL_CELLS];
    div_d[0].cmd = mul_d[MUL_CELLS].cmd;
    div_d[0].rem = '0;
    div_d[0].dq  = mul_d[MUL_CELLS].r;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    iqh_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .divisor_i (size_eff),
      .vld_i     (div_v[i]),
      .d_i       (div_d[i]),
      .vld_o     (div_v[i+1]),
      .d_o       (div_d[i+1])
    );
  end

  // Result fields of the mode not selected read zero. Remainders keep their low
  // 32 bits when the table size exceeds 2^32.
  always_comb begin
    out_ch.valid            = div_v[DIV_CELLS];
    out_ch.address_out      = '0;
    out_ch.quotient_out     = '0;
    out_ch.recovered_item   = '0;
    out_ch.recovered_parent = '0;
    if (div_d[DIV_CELLS].cmd == CMD_RECOVER) begin
      out_ch.recovered_item   = div_d[DIV_CELLS].dq;
      out_ch.recovered_parent = div_d[DIV_CELLS].rem[ADDR_W-1:0];
    end else begin
      out_ch.quotient_out = div_d[DIV_CELLS].dq;
      out_ch.address_out  = div_d[DIV_CELLS].rem[ADDR_W-1:0];
    end
  end

endmodule
